FILE: sv/grid_cell_max_response_select_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid cell maximum response selector
// Concurrent checks that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_MAX_RESPONSE_SELECT_MACROS_SVH
`define GRID_CELL_MAX_RESPONSE_SELECT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define GCMS_ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("gcms assertion failed");

// consequent must hold in the cycle after the antecedent
`define GCMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gcms assertion failed");

`else

`define GCMS_ASSERT_HOLDS(lbl, clk, rstn, prop)
`define GCMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: sv/gcms_pkg.sv
// ----------------------------------------------------------------------------
// gcms_pkg
// Shared types, register indexes and helper functions of the grid selector.
// ----------------------------------------------------------------------------
`default_nettype none

package gcms_pkg;

    // default size of the cell store
    localparam int CELLS_DEFAULT = 64;

    // field widths
    localparam int POS_W   = 16;
    localparam int RESP_W  = 16;
    localparam int ID_W    = 16;
    localparam int INV_W   = 17;
    localparam int COUNT_W = 7;
    localparam int AXIS_W  = 6;
    localparam int PROD_W  = POS_W + INV_W;
    localparam int ENTRY_W = 2 * POS_W + RESP_W + ID_W;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = INV_W;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_INV_WIDTH  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_INV_HEIGHT = 3'd3;
    localparam logic [CFG_AW-1:0] REG_GRID_COLS  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_GRID_ROWS  = 3'd5;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_CAP_Y,
        ST_MUL_C,
        ST_ADDR,
        ST_CMP,
        ST_FL_SCAN,
        ST_FL_OUT,
        ST_FL_EMPTY
    } gcms_state_t;

    // control group from sequencer to cell store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_all;
    } gcms_store_ctrl_t;

    // zero means one column, above 64 means 64
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] r;
        if (n == '0) begin
            r = 7'd1;
        end else if (n > 7'd64) begin
            r = 7'd64;
        end else begin
            r = n;
        end
        return r;
    endfunction

    // offset to the origin, saturated at zero
    function automatic logic [POS_W-1:0] sat_offset(input logic [POS_W-1:0] pos,
                                                    input logic [POS_W-1:0] origin);
        logic [POS_W-1:0] r;
        if (pos >= origin) begin
            r = pos - origin;
        end else begin
            r = '0;
        end
        return r;
    endfunction

    // integer part of the scaled offset, clamped to count - 1
    function automatic logic [AXIS_W-1:0] clamp_index(input logic [PROD_W-1:16] q,
                                                      input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] lim;
        logic [AXIS_W-1:0]  r;
        lim = count - 7'd1;
        if (q > {{(PROD_W-16-COUNT_W){1'b0}}, lim}) begin
            r = lim[AXIS_W-1:0];
        end else begin
            r = q[AXIS_W+15:16];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/gcms_mul_unit.sv
// ----------------------------------------------------------------------------
// gcms_mul_unit
// Shared 16 x 17 multiplier with a registered product, reused for both axes
// and for the row times columns step.
// ----------------------------------------------------------------------------
`default_nettype none

module gcms_mul_unit (
    input  wire logic                       aclk,
    input  wire logic [gcms_pkg::POS_W-1:0]  op_a,
    input  wire logic [gcms_pkg::INV_W-1:0]  op_b,
    output logic      [gcms_pkg::PROD_W-1:0] prod
);
    import gcms_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // one product a cycle
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: sv/gcms_cell_store.sv
// ----------------------------------------------------------------------------
// gcms_cell_store
// Per-cell best keypoint memory with registered read and flop valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gcms_cell_store #(
    parameter int CELLS = gcms_pkg::CELLS_DEFAULT,
    parameter int AW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire gcms_pkg::gcms_store_ctrl_t    ctrl,
    input  wire logic [AW-1:0]                 rd_addr,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [gcms_pkg::ENTRY_W-1:0]  wr_data,
    output logic      [gcms_pkg::ENTRY_W-1:0]  rd_data,
    output logic      [CELLS-1:0]              valid
);
    import gcms_pkg::*;

    logic [ENTRY_W-1:0] cell_mem [CELLS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [CELLS-1:0]   valid_reg;

    // entry write and registered read
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            cell_mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= cell_mem[rd_addr];
        end
    end

    // valid marks: set on write, all cleared after a flush
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.clear_all) begin
            valid_reg <= '0;
        end else if (ctrl.wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

`default_nettype wire

FILE: sv/grid_cell_max_response_select.sv
// Insert: accepting word, 3 multiplier passes, row capture, store read, compare and
//   write; a word whose cell lies beyond the store ends after the address step.
// Flush: a start step, then a scan over the cells up to the last occupied one, each
//   occupied cell read and emitted, held by any m_tready stalls; empty grid: one empty last word.
// Reset: synchronous, active low; clears valid marks, sequencer, output valid
//   and loads the register defaults. No clearing pass over the store.
// ----------------------------------------------------------------------------
// grid_cell_max_response_select
// Bins keypoints into a grid, keeps the highest response per cell and emits
// the winners of all occupied cells on a flush.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_cell_max_response_select_macros.svh"

module grid_cell_max_response_select #(
    parameter int CELLS = gcms_pkg::CELLS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [gcms_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [gcms_pkg::CFG_DW-1:0]   cfg_wdata,
    // request words
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,   // pos_x, pos_y, response, point_id
    input  wire logic                          s_tuser,   // req_type
    // result words
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [71:0]                   m_tdata,   // win_x, win_y, win_response,
                                                          // win_id, cell_index, zero pad
    output logic                               m_tuser,   // empty_res
    output logic                               m_tlast    // last
);
    import gcms_pkg::*;

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SUM_W = 13;

    // configuration registers
    logic [POS_W-1:0]   origin_x_reg, origin_y_reg;
    logic [INV_W-1:0]   inv_w_reg, inv_h_reg;
    logic [COUNT_W-1:0] cols_reg, rows_reg;

    // sequencer
    gcms_state_t        state_reg, state_next;
    logic [POS_W-1:0]   pos_x_reg, pos_y_reg;
    logic [RESP_W-1:0]  resp_reg;
    logic [ID_W-1:0]    id_reg;
    logic [AXIS_W-1:0]  col_reg, col_next;
    logic [AXIS_W-1:0]  row_reg, row_next;
    logic [AW-1:0]      cell_reg, cell_next;
    logic [AW-1:0]      scan_idx_reg, scan_idx_next;

    // output register
    logic               m_tvalid_reg;
    logic [ENTRY_W-1:0] out_entry_reg;
    logic [AXIS_W-1:0]  out_cell_reg;
    logic               out_empty_reg, out_last_reg;

    // datapath
    logic [COUNT_W-1:0] cols_eff, rows_eff;
    logic [POS_W-1:0]   mul_a;
    logic [INV_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod;
    logic [SUM_W-1:0]   cell_sum;
    gcms_store_ctrl_t   store_ctrl;
    logic [AW-1:0]      mem_rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [CELLS-1:0]   valid_vec;
    logic               s_accept, out_free, out_load, out_empty, out_last;
    logic               last_hit, take_new;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cols_eff = clamp_count(cols_reg);
    assign rows_eff = clamp_count(rows_reg);
    assign cell_sum = SUM_W'(prod[11:0]) + SUM_W'(col_reg);
    assign take_new = !valid_vec[cell_reg] ||
                      (resp_reg > rd_data[2*POS_W+RESP_W-1:2*POS_W]);

    // no occupied cell above the one being emitted
    always_comb begin
        last_hit = 1'b1;
        for (int i = 0; i < CELLS; i++) begin
            if (valid_vec[i] && (i > int'(scan_idx_reg))) begin
                last_hit = 1'b0;
            end
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_X: begin
                mul_a = sat_offset(pos_x_reg, origin_x_reg);
                mul_b = inv_w_reg;
            end
            ST_MUL_Y: begin
                mul_a = sat_offset(pos_y_reg, origin_y_reg);
                mul_b = inv_h_reg;
            end
            ST_MUL_C: begin
                mul_a = POS_W'(row_reg);
                mul_b = INV_W'(cols_eff);
            end
            default: begin
            end
        endcase
    end

    gcms_mul_unit u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    gcms_cell_store #(
        .CELLS (CELLS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (store_ctrl),
        .rd_addr (mem_rd_addr),
        .wr_addr (cell_reg),
        .wr_data ({id_reg, resp_reg, pos_y_reg, pos_x_reg}),
        .rd_data (rd_data),
        .valid   (valid_vec)
    );

    // next state and control
    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        cell_next     = cell_reg;
        scan_idx_next = scan_idx_reg;
        store_ctrl    = '0;
        mem_rd_addr   = scan_idx_reg;
        out_load      = 1'b0;
        out_empty     = 1'b0;
        out_last      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_FLUSH) begin
                        scan_idx_next = '0;
                        state_next    = (valid_vec == '0) ? ST_FL_EMPTY : ST_FL_SCAN;
                    end else begin
                        state_next = ST_MUL_X;
                    end
                end
            end
            ST_MUL_X: begin
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                col_next   = clamp_index(prod[PROD_W-1:16], cols_eff);
                state_next = ST_CAP_Y;
            end
            ST_CAP_Y: begin
                row_next   = clamp_index(prod[PROD_W-1:16], rows_eff);
                state_next = ST_MUL_C;
            end
            ST_MUL_C: begin
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                // cells beyond the store are dropped
                if (cell_sum < SUM_W'(CELLS)) begin
                    cell_next        = cell_sum[AW-1:0];
                    mem_rd_addr      = cell_sum[AW-1:0];
                    store_ctrl.rd_en = 1'b1;
                    state_next       = ST_CMP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CMP: begin
                // strictly greater wins, so the earliest stays on a tie
                store_ctrl.wr_en = take_new;
                state_next       = ST_IDLE;
            end
            ST_FL_SCAN: begin
                if (valid_vec[scan_idx_reg]) begin
                    store_ctrl.rd_en = 1'b1;
                    state_next       = ST_FL_OUT;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_FL_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = last_hit;
                    if (last_hit) begin
                        store_ctrl.clear_all = 1'b1;
                        state_next           = ST_IDLE;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                        state_next    = ST_FL_SCAN;
                    end
                end
            end
            ST_FL_EMPTY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_empty  = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            inv_w_reg    <= 17'd4096;
            inv_h_reg    <= 17'd4096;
            cols_reg     <= 7'd8;
            rows_reg     <= 7'd8;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ORIGIN_X:   origin_x_reg <= cfg_wdata[POS_W-1:0];
                REG_ORIGIN_Y:   origin_y_reg <= cfg_wdata[POS_W-1:0];
                REG_INV_WIDTH:  inv_w_reg    <= cfg_wdata;
                REG_INV_HEIGHT: inv_h_reg    <= cfg_wdata;
                REG_GRID_COLS:  cols_reg     <= cfg_wdata[COUNT_W-1:0];
                REG_GRID_ROWS:  rows_reg     <= cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // request payload and working registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pos_x_reg <= s_tdata[15:0];
            pos_y_reg <= s_tdata[31:16];
            resp_reg  <= s_tdata[47:32];
            id_reg    <= s_tdata[63:48];
        end
        col_reg      <= col_next;
        row_reg      <= row_next;
        cell_reg     <= cell_next;
        scan_idx_reg <= scan_idx_next;
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_entry_reg <= out_empty ? '0 : rd_data;
            out_cell_reg  <= out_empty ? '0 : AXIS_W'(scan_idx_reg);
            out_empty_reg <= out_empty;
            out_last_reg  <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_cell_reg, out_entry_reg};
    assign m_tuser  = out_empty_reg;
    assign m_tlast  = out_last_reg;

    // checks
    `GCMS_ASSERT_NEXT(a_clear_after_last, aclk, aresetn,
        (state_reg == ST_FL_OUT) && out_free && last_hit, valid_vec == '0)
    `GCMS_ASSERT_HOLDS(a_scan_has_work, aclk, aresetn,
        (state_reg != ST_FL_SCAN) || (valid_vec != '0))
    `GCMS_ASSERT_HOLDS(a_empty_is_last, aclk, aresetn,
        !(m_tvalid && m_tuser) || m_tlast)
    `GCMS_ASSERT_NEXT(a_insert_path, aclk, aresetn,
        s_accept && (s_tuser == REQ_INSERT), state_reg == ST_MUL_X)

endmodule

`default_nettype wire
